@@ rtl/radio_packet_framer_top_macros.svh @@
// Assertion macros for the radio packet framer.
`ifndef RADIO_PACKET_FRAMER_TOP_MACROS_SVH
`define RADIO_PACKET_FRAMER_TOP_MACROS_SVH
// Same-cycle implication, checked on clock, quiet in reset.
`define RPF_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("framer check failed");
// Next-cycle implication, checked on clock, quiet in reset.
`define RPF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("framer check failed");
`endif

@@ rtl/rpf_pkg.sv @@
// Types, codes and helpers shared by the radio packet framer modules.
package rpf_pkg;
   localparam int MAX_RES = 8;

   localparam logic [2:0] CMD_EVENT  = 3'd0;
   localparam logic [2:0] CMD_START  = 3'd1;
   localparam logic [2:0] CMD_WRITE  = 3'd2;
   localparam logic [2:0] CMD_READ   = 3'd3;
   localparam logic [2:0] CMD_FINISH = 3'd4;

   localparam logic [3:0] ACT_TX_BYTE      = 4'd0;
   localparam logic [3:0] ACT_IDLE         = 4'd1;
   localparam logic [3:0] ACT_RX_ON        = 4'd2;
   localparam logic [3:0] ACT_TX_ON        = 4'd3;
   localparam logic [3:0] ACT_FIFO_RESET   = 4'd4;
   localparam logic [3:0] ACT_FIFO_ARM     = 4'd5;
   localparam logic [3:0] ACT_STATUS_CLEAR = 4'd6;
   localparam logic [3:0] ACT_REINIT       = 4'd7;
   localparam logic [3:0] ACT_CLAIM        = 4'd8;
   localparam logic [3:0] ACT_RELEASE      = 4'd9;
   localparam logic [3:0] ACT_READ         = 4'd10;
   localparam logic [3:0] ACT_RX_LENGTH    = 4'd11;
   localparam logic [3:0] ACT_REFUSED      = 4'd12;

   localparam logic [3:0] MODE_OFF      = 4'd0;
   localparam logic [3:0] MODE_RX       = 4'd1;
   localparam logic [3:0] MODE_NEW      = 4'd2;
   localparam logic [3:0] MODE_TX       = 4'd3;
   localparam logic [3:0] MODE_PRE_A    = 4'd4;
   localparam logic [3:0] MODE_PRE_B    = 4'd5;
   localparam logic [3:0] MODE_SYNC_A   = 4'd6;
   localparam logic [3:0] MODE_SYNC_B   = 4'd7;
   localparam logic [3:0] MODE_SIZE_HI  = 4'd8;
   localparam logic [3:0] MODE_SIZE_LO  = 4'd9;
   localparam logic [3:0] MODE_DATA     = 4'd10;
   localparam logic [3:0] MODE_DATA_END = 4'd11;
   localparam logic [3:0] MODE_TRL_A    = 4'd12;
   localparam logic [3:0] MODE_TRL_B    = 4'd13;
   localparam logic [3:0] MODE_END      = 4'd14;

   localparam logic [1:0] SEL_RAM  = 2'd0;
   localparam logic [1:0] SEL_HDR0 = 2'd1;
   localparam logic [1:0] SEL_HDR1 = 2'd2;
   localparam logic [1:0] SEL_ZERO = 2'd3;

   localparam logic [7:0] BYTE_PREAMBLE = 8'hAA;
   localparam logic [7:0] BYTE_SYNC_A   = 8'h2D;
   localparam logic [7:0] BYTE_SYNC_B   = 8'hD4;
   localparam logic [7:0] BYTE_TX_OFF   = 8'h08;

   typedef struct packed {
      logic [2:0]  cmd;
      logic        power_on_reset_flag;
      logic        fifo_overflow_flag;
      logic        fifo_ready_flag;
      logic [7:0]  received_byte;
      logic        host_busy;
      logic [14:0] send_length;
      logic [8:0]  buffer_index;
      logic [7:0]  buffer_value;
   } rpf_item_type;

   typedef struct packed {
      logic [3:0]  action;
      logic [14:0] value;
   } rpf_res_type;

   typedef struct packed {
      logic                      load;
      logic [3:0]                count;
      rpf_res_type [MAX_RES-1:0] list;
   } rpf_res_set_type;

   function automatic rpf_res_set_type rpf_add(rpf_res_set_type rs_in, logic [3:0] act,
                                               logic [14:0] val);
      rpf_res_set_type rs;
      rs = rs_in;
      rs.list[rs.count[2:0]] = '{action: act, value: val};
      rs.count = rs.count + 4'd1;
      return rs;
   endfunction
endpackage

@@ rtl/rpf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module rpf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

@@ rtl/rpf_ctrl.sv @@
// Framer control: item stage, link state, buffer access and result building.
module rpf_ctrl #(
   parameter int BUFFER_BYTES = 512
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  rpf_pkg::rpf_item_type           req_item,
   output logic                            req_ready,
   input  logic                            buf_free,
   output rpf_pkg::rpf_res_set_type        res_set,
   output logic                            ram_we,
   output logic [$clog2(BUFFER_BYTES)-1:0] ram_waddr,
   output logic [7:0]                      ram_wdata,
   output logic                            ram_re,
   output logic [$clog2(BUFFER_BYTES)-1:0] ram_raddr,
   input  logic [7:0]                      ram_rdata
);
   import rpf_pkg::*;

   localparam int AW = $clog2(BUFFER_BYTES);
   localparam int CW = (AW + 1 > 10) ? AW + 1 : 10;

   logic                  a_valid_ff, a_valid_in;
   rpf_item_type          item_ff;
   logic [1:0]            sel_ff, sel_in;
   logic [3:0]            mode_ff, mode_in;
   logic [14:0]           bp_ff, bp_in;
   logic [14:0]           tl_ff, tl_in;
   logic [AW-1:0]         txa_ff, txa_in;
   logic [7:0]            hdr0_ff, hdr0_in, hdr1_ff, hdr1_in;

   logic                  accept, fire;
   logic [CW-1:0]         req_idx, a_idx;
   logic                  req_idx_ok, a_idx_ok;
   logic [7:0]            rd_byte;
   logic [14:0]           hdr_len;
   logic [14:0]           bp_next;
   logic                  we_c;
   rpf_res_set_type       rs;

   assign req_ready = !a_valid_ff;
   assign accept    = req_valid && req_ready;
   assign fire      = a_valid_ff && buf_free;

   // Issue the buffer read as the item comes in.
   assign req_idx    = CW'(req_item.buffer_index);
   assign req_idx_ok = req_idx < CW'(BUFFER_BYTES);
   assign ram_re     = accept;
   assign ram_raddr  = (req_item.cmd == CMD_READ) ? req_idx[AW-1:0] : txa_ff;

   always_comb begin
      if (req_item.cmd == CMD_READ) begin
         if (!req_idx_ok)             sel_in = SEL_ZERO;
         else if (req_idx == CW'(0))  sel_in = SEL_HDR0;
         else if (req_idx == CW'(1))  sel_in = SEL_HDR1;
         else                         sel_in = SEL_RAM;
      end else begin
         if (txa_ff == AW'(0))        sel_in = SEL_HDR0;
         else if (txa_ff == AW'(1))   sel_in = SEL_HDR1;
         else                         sel_in = SEL_RAM;
      end
   end

   assign a_idx    = CW'(item_ff.buffer_index);
   assign a_idx_ok = a_idx < CW'(BUFFER_BYTES);
   assign hdr_len  = {hdr0_ff[6:0], hdr1_ff};

   // Header bytes live in registers; the RAM copy of entries 0 and 1 is never read.
   always_comb begin
      case (sel_ff)
         SEL_HDR0: rd_byte = hdr0_ff;
         SEL_HDR1: rd_byte = hdr1_ff;
         SEL_ZERO: rd_byte = 8'd0;
         default:  rd_byte = ram_rdata;
      endcase
   end

   always_comb begin
      rs        = '0;
      mode_in   = mode_ff;
      bp_in     = bp_ff;
      tl_in     = tl_ff;
      txa_in    = txa_ff;
      hdr0_in   = hdr0_ff;
      hdr1_in   = hdr1_ff;
      we_c      = 1'b0;
      ram_waddr = a_idx[AW-1:0];
      ram_wdata = item_ff.buffer_value;
      bp_next   = bp_ff + 15'd1;
      case (item_ff.cmd)
         CMD_EVENT: begin
            if (item_ff.power_on_reset_flag || item_ff.fifo_overflow_flag) begin
               rs      = rpf_add(rs, ACT_REINIT, 15'd0);
               mode_in = MODE_RX;
               bp_in   = 15'd0;
            end else if (item_ff.fifo_ready_flag) begin
               case (mode_ff)
                  MODE_RX: begin
                     if ((bp_ff != 15'd0) ? (bp_ff < 15'(BUFFER_BYTES))
                                          : !item_ff.host_busy) begin
                        rs        = rpf_add(rs, ACT_CLAIM, 15'd0);
                        ram_waddr = bp_ff[AW-1:0];
                        ram_wdata = item_ff.received_byte;
                        we_c      = bp_ff >= 15'd2;
                        if (bp_ff == 15'd0) hdr0_in = item_ff.received_byte;
                        if (bp_ff == 15'd1) hdr1_in = item_ff.received_byte;
                        bp_in = bp_next;
                        if (bp_next > 15'd2 &&
                            {1'b0, bp_next} > ({1'b0, hdr_len} + 16'd1)) begin
                           rs      = rpf_add(rs, ACT_IDLE, 15'd0);
                           rs      = rpf_add(rs, ACT_RX_ON, 15'd0);
                           mode_in = MODE_NEW;
                        end
                     end else begin
                        // Overrun or busy host: abort and restart receive.
                        if (bp_ff != 15'd0) rs = rpf_add(rs, ACT_RELEASE, 15'd0);
                        rs      = rpf_add(rs, ACT_IDLE, 15'd0);
                        rs      = rpf_add(rs, ACT_RX_ON, 15'd0);
                        rs      = rpf_add(rs, ACT_FIFO_RESET, 15'd0);
                        rs      = rpf_add(rs, ACT_FIFO_ARM, 15'd0);
                        bp_in   = 15'd0;
                        mode_in = MODE_RX;
                     end
                  end
                  MODE_SYNC_A: begin
                     rs      = rpf_add(rs, ACT_TX_BYTE, {7'd0, BYTE_SYNC_A});
                     mode_in = mode_ff + 4'd1;
                  end
                  MODE_SYNC_B: begin
                     rs      = rpf_add(rs, ACT_TX_BYTE, {7'd0, BYTE_SYNC_B});
                     mode_in = mode_ff + 4'd1;
                  end
                  MODE_SIZE_HI: begin
                     rs      = rpf_add(rs, ACT_TX_BYTE, {7'd0, hdr0_ff});
                     mode_in = mode_ff + 4'd1;
                  end
                  MODE_SIZE_LO: begin
                     rs      = rpf_add(rs, ACT_TX_BYTE, {7'd0, hdr1_ff});
                     mode_in = mode_ff + 4'd1;
                  end
                  MODE_DATA: begin
                     rs     = rpf_add(rs, ACT_TX_BYTE, {7'd0, rd_byte});
                     bp_in  = bp_next;
                     txa_in = (txa_ff == AW'(BUFFER_BYTES - 1)) ? '0 : txa_ff + AW'(1);
                     if (bp_next >= tl_ff) mode_in = MODE_DATA_END;
                  end
                  MODE_END: begin
                     rs      = rpf_add(rs, ACT_TX_BYTE, {7'd0, BYTE_TX_OFF});
                     rs      = rpf_add(rs, ACT_RELEASE, 15'd0);
                     rs      = rpf_add(rs, ACT_RX_ON, 15'd0);
                     rs      = rpf_add(rs, ACT_FIFO_RESET, 15'd0);
                     rs      = rpf_add(rs, ACT_FIFO_ARM, 15'd0);
                     rs      = rpf_add(rs, ACT_STATUS_CLEAR, 15'd0);
                     bp_in   = 15'd0;
                     mode_in = MODE_RX;
                  end
                  MODE_OFF, MODE_NEW: begin
                     rs = rpf_add(rs, ACT_STATUS_CLEAR, 15'd0);
                  end
                  MODE_TX, MODE_PRE_A, MODE_PRE_B, MODE_DATA_END, MODE_TRL_A,
                  MODE_TRL_B: begin
                     rs      = rpf_add(rs, ACT_TX_BYTE, {7'd0, BYTE_PREAMBLE});
                     mode_in = mode_ff + 4'd1;
                  end
                  default: ;
               endcase
               if (mode_in >= MODE_TX) rs = rpf_add(rs, ACT_CLAIM, 15'd0);
            end
         end
         CMD_START: begin
            if (mode_ff > MODE_RX || (mode_ff == MODE_RX && bp_ff != 15'd0)) begin
               rs = rpf_add(rs, ACT_REFUSED, 15'd0);
            end else begin
               tl_in   = item_ff.send_length;
               hdr0_in = {1'b0, item_ff.send_length[14:8]};
               hdr1_in = item_ff.send_length[7:0];
               mode_in = MODE_TX;
               bp_in   = 15'd0;
               txa_in  = AW'(2);
               rs      = rpf_add(rs, ACT_TX_ON, 15'd0);
               rs      = rpf_add(rs, ACT_CLAIM, 15'd0);
            end
         end
         CMD_WRITE: begin
            if (a_idx_ok) begin
               we_c = a_idx >= CW'(2);
               if (a_idx == CW'(0)) hdr0_in = item_ff.buffer_value;
               if (a_idx == CW'(1)) hdr1_in = item_ff.buffer_value;
            end
         end
         CMD_READ: begin
            rs = rpf_add(rs, ACT_READ, {7'd0, rd_byte});
         end
         CMD_FINISH: begin
            if (mode_ff != MODE_NEW) begin
               rs = rpf_add(rs, ACT_RX_LENGTH, 15'd0);
            end else if (hdr0_ff[7] || hdr_len == 15'd0) begin
               // Source-routed or empty packet: release and listen again.
               rs      = rpf_add(rs, ACT_RELEASE, 15'd0);
               rs      = rpf_add(rs, ACT_RX_ON, 15'd0);
               rs      = rpf_add(rs, ACT_FIFO_RESET, 15'd0);
               rs      = rpf_add(rs, ACT_FIFO_ARM, 15'd0);
               rs      = rpf_add(rs, ACT_RX_LENGTH, 15'd0);
               bp_in   = 15'd0;
               mode_in = MODE_RX;
            end else begin
               rs      = rpf_add(rs, ACT_RX_LENGTH, hdr_len);
               mode_in = MODE_OFF;
            end
         end
         default: ;
      endcase
      rs.load = fire;
   end

   assign res_set    = rs;
   assign ram_we     = fire && we_c;
   assign a_valid_in = accept ? 1'b1 : (fire ? 1'b0 : a_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         mode_ff    <= MODE_OFF;
         bp_ff      <= 15'd0;
         tl_ff      <= 15'd0;
         txa_ff     <= '0;
      end else begin
         a_valid_ff <= a_valid_in;
         if (fire) begin
            mode_ff <= mode_in;
            bp_ff   <= bp_in;
            tl_ff   <= tl_in;
            txa_ff  <= txa_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_item;
         sel_ff  <= sel_in;
      end
      if (fire) begin
         hdr0_ff <= hdr0_in;
         hdr1_ff <= hdr1_in;
      end
   end
endmodule

@@ rtl/rpf_rsp_buf.sv @@
// Result buffer: holds one item's results and hands them out one per transfer.
module rpf_rsp_buf (
   input  logic                     clock,
   input  logic                     reset,
   input  rpf_pkg::rpf_res_set_type res_set,
   output logic                     buf_free,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [3:0]               rsp_action,
   output logic [14:0]              rsp_value,
   output logic                     rsp_last
);
   import rpf_pkg::*;

   rpf_res_type [MAX_RES-1:0] list_ff;
   logic [3:0]                cnt_ff, cnt_in;
   logic [2:0]                idx_ff, idx_in;
   logic                      xfer;

   assign rsp_tvalid = cnt_ff != 4'd0;
   assign rsp_last   = {1'b0, idx_ff} == (cnt_ff - 4'd1);
   assign rsp_action = list_ff[idx_ff].action;
   assign rsp_value  = list_ff[idx_ff].value;
   assign xfer       = rsp_tvalid && rsp_tready;
   assign buf_free   = !rsp_tvalid || (xfer && rsp_last);

   always_comb begin
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      if (res_set.load) begin
         cnt_in = res_set.count;
         idx_in = 3'd0;
      end else if (xfer) begin
         if (rsp_last) cnt_in = 4'd0;
         else          idx_in = idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 4'd0;
         idx_ff <= 3'd0;
      end else begin
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_set.load) begin
         list_ff <= res_set.list;
      end
   end
endmodule

@@ rtl/radio_packet_framer_top.sv @@
// Top level of the radio packet framer: stream ports, control, buffer RAM, result buffer.
// The framer turns host commands and radio FIFO events into a stream of radio actions.
// Each request transfer is one command (tuser) with its status flags and data; it yields
// zero to six response transfers, the final one flagged by tlast. A request is taken into
// a one-entry stage that issues the packet-buffer read, and it is resolved against the
// link state once the result buffer is free, so the next request can be taken while the
// previous results still drain. Results leave one per cycle while rsp_tready is high. The
// packet buffer is a BUFFER_BYTES-deep byte RAM with one write and one registered read
// port; the two length header bytes are held in registers. Entries never written read as
// unknown data.
module radio_packet_framer_top #(
   parameter int BUFFER_BYTES = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [0] power_on_reset_flag, [1] fifo_overflow_flag, [2] fifo_ready_flag,
   // [10:3] received_byte, [11] host_busy, [26:12] send_length,
   // [35:27] buffer_index, [43:36] buffer_value, [47:44] zero
   input  logic [47:0] req_tdata,
   // [2:0] cmd
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [14:0] value, [15] zero
   output logic [15:0] rsp_tdata,
   // [3:0] action
   output logic [3:0]  rsp_tuser,
   output logic        rsp_tlast
);
   import rpf_pkg::*;

   localparam int AW = $clog2(BUFFER_BYTES);

   rpf_item_type    req_item;
   rpf_res_set_type res_set;
   logic            buf_free;
   logic            ram_we, ram_re;
   logic [AW-1:0]   ram_waddr, ram_raddr;
   logic [7:0]      ram_wdata, ram_rdata;
   logic [14:0]     rsp_value;

   // Unpack the request transfer.
   assign req_item.cmd                 = req_tuser;
   assign req_item.power_on_reset_flag = req_tdata[0];
   assign req_item.fifo_overflow_flag  = req_tdata[1];
   assign req_item.fifo_ready_flag     = req_tdata[2];
   assign req_item.received_byte       = req_tdata[10:3];
   assign req_item.host_busy           = req_tdata[11];
   assign req_item.send_length         = req_tdata[26:12];
   assign req_item.buffer_index        = req_tdata[35:27];
   assign req_item.buffer_value        = req_tdata[43:36];

   rpf_ctrl #(.BUFFER_BYTES(BUFFER_BYTES)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_item  (req_item),
      .req_ready (req_tready),
      .buf_free  (buf_free),
      .res_set   (res_set),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_re    (ram_re),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata)
   );

   rpf_ram #(.WIDTH(8), .DEPTH(BUFFER_BYTES)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   rpf_rsp_buf u_rsp_buf (
      .clock      (clock),
      .reset      (reset),
      .res_set    (res_set),
      .buf_free   (buf_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_action (rsp_tuser),
      .rsp_value  (rsp_value),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, rsp_value};

`include "radio_packet_framer_top_macros.svh"

   // A taken request holds the stage for its resolve cycle.
   `RPF_ASSERT_NEXT(a_req_stage_busy, req_tvalid && req_tready, !req_tready)
   // Never overwrite results that are still waiting.
   `RPF_ASSERT_NOW(a_load_when_free, res_set.load, buf_free)
   // One request never yields more than the buffer holds.
   `RPF_ASSERT_NOW(a_count_fits, res_set.load, res_set.count <= 4'(MAX_RES))
endmodule
